/* hdl/text_glyph_column_generator_unit_macros.svh */
// Assertion helpers for the top design file.
`ifndef TEXT_GLYPH_COLUMN_GENERATOR_UNIT_MACROS_SVH
`define TEXT_GLYPH_COLUMN_GENERATOR_UNIT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define TGCG_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define TGCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/tgcg_pkg.sv */
package tgcg_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_DIGITS  = 5;
    // Accept only when a whole number's worth of cells still fits.
    localparam int FREE_LIMIT  = QUEUE_DEPTH - MAX_DIGITS;

    localparam logic [7:0] FONT_FIRST = 8'h20;
    localparam logic [7:0] FONT_LAST  = 8'h80;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] BLANK_COL  = 8'h00;
    localparam logic [2:0] LAST_POS   = 3'd4;
    localparam logic [2:0] PAD_COL    = 3'd5;

    localparam logic MODE_CHAR   = 1'b0;
    localparam logic MODE_NUMBER = 1'b1;

    localparam int GLYPH_W = 40;
    localparam int CELL_W  = 9;

    typedef struct packed {
        logic       last;
        logic [7:0] code;
    } cell_t;

    typedef struct packed {
        logic  en;
        cell_t entry;
    } wr_t;

    // Column 0 of a glyph sits in the top byte, column 4 in the bottom byte.
    localparam logic [GLYPH_W-1:0] GLYPH_ROM [0:96] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700,
        40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
        40'h3649552250, 40'h0005030000, 40'h001c224100,
        40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000,
        40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
        40'h4261514946, 40'h2141454b31, 40'h1814127f10,
        40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000,
        40'h0056360000, 40'h0814224100, 40'h1414141414,
        40'h0041221408, 40'h0201510906, 40'h324979413e,
        40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
        40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
        40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
        40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
        40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
        40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204,
        40'h4040404040, 40'h0001020400, 40'h2054545478,
        40'h7f48444438, 40'h3844444420, 40'h384444487f,
        40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
        40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
        40'h7c08040478, 40'h3844444438, 40'h7c14141408,
        40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
        40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
        40'h4464544c44, 40'h0008364100, 40'h00007f0000,
        40'h0041360800, 40'h1008081008, 40'h1f247c241f,
        40'h0006090906
    };

    function automatic logic [GLYPH_W-1:0] glyph_cols(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - FONT_FIRST;
        if (code >= FONT_FIRST && code <= FONT_LAST)
        begin
            return GLYPH_ROM[offs[6:0]];
        end
        return '0;
    endfunction

    // k times the decimal weight of digit position pos (position 0 is the ten thousands).
    function automatic logic [16:0] digit_thresh(input logic [2:0] pos, input int k);
        case (pos)
            3'd0:    return 17'(k * 10000);
            3'd1:    return 17'(k * 1000);
            3'd2:    return 17'(k * 100);
            3'd3:    return 17'(k * 10);
            default: return 17'(k);
        endcase
    endfunction

endpackage

/* hdl/tgcg_ram.sv */
module tgcg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/tgcg_conv.sv */
module tgcg_conv (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              mode,
    input  logic [7:0]        char_code,
    input  logic [15:0]       number,
    output logic              active,
    output tgcg_pkg::wr_t     wr
);

    logic        active_reg, active_next;
    logic [15:0] rem_reg, rem_next;
    logic [2:0]  pos_reg, pos_next;
    logic        started_reg, started_next;
    logic [3:0]  digit;
    logic [16:0] sub;
    logic        emit_digit;

    // One decimal digit per cycle: count how many multiples of the weight fit.
    always_comb
    begin
        digit = 4'd0;
        sub   = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if ({1'b0, rem_reg} >= tgcg_pkg::digit_thresh(pos_reg, k))
            begin
                digit = 4'(k);
                sub   = tgcg_pkg::digit_thresh(pos_reg, k);
            end
        end
    end

    // Leading zeros are dropped, but the units digit always appears.
    assign emit_digit = (digit != 4'd0) || started_reg || (pos_reg == tgcg_pkg::LAST_POS);

    always_comb
    begin
        active_next   = active_reg;
        rem_next      = rem_reg;
        pos_next      = pos_reg;
        started_next  = started_reg;
        wr.en         = 1'b0;
        wr.entry.last = 1'b1;
        wr.entry.code = char_code;
        if (active_reg)
        begin
            wr.en         = emit_digit;
            wr.entry.last = (pos_reg == tgcg_pkg::LAST_POS);
            wr.entry.code = tgcg_pkg::DIGIT_ZERO + {4'd0, digit};
            rem_next      = rem_reg - sub[15:0];
            pos_next      = pos_reg + 3'd1;
            started_next  = emit_digit;
            if (pos_reg == tgcg_pkg::LAST_POS)
            begin
                active_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (mode == tgcg_pkg::MODE_CHAR)
            begin
                wr.en = 1'b1;
            end
            else
            begin
                active_next  = 1'b1;
                rem_next     = number;
                pos_next     = 3'd0;
                started_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        pos_reg     <= pos_next;
        started_reg <= started_next;
    end

    assign active = active_reg;

endmodule

/* hdl/tgcg_emit.sv */
module tgcg_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            avail,
    input  tgcg_pkg::cell_t rd_cell,
    output logic            rd_en,
    output logic            strobe,
    output logic [7:0]      column_byte,
    output logic            last
);

    logic                        rdv_reg;
    logic                        act_reg, act_next;
    logic [2:0]                  col_reg, col_next;
    logic [tgcg_pkg::GLYPH_W-1:0] glyph_reg;
    logic                        cell_last_reg;
    logic                        strobe_reg;
    logic [7:0]                  byte_reg, byte_next;
    logic                        last_reg;
    logic                        final_col;

    assign final_col = (col_reg == tgcg_pkg::PAD_COL);

    // The next cell is fetched during the last glyph column of the current one,
    // so that its glyph is loaded exactly as the padding column goes out.
    assign rd_en = avail && !rdv_reg
                   && (!act_reg || col_reg == tgcg_pkg::LAST_POS || final_col);

    always_comb
    begin
        case (col_reg)
            3'd0:    byte_next = glyph_reg[39:32];
            3'd1:    byte_next = glyph_reg[31:24];
            3'd2:    byte_next = glyph_reg[23:16];
            3'd3:    byte_next = glyph_reg[15:8];
            3'd4:    byte_next = glyph_reg[7:0];
            default: byte_next = tgcg_pkg::BLANK_COL;
        endcase
    end

    always_comb
    begin
        act_next = act_reg;
        col_next = col_reg;
        if (act_reg)
        begin
            col_next = col_reg + 3'd1;
            if (final_col)
            begin
                act_next = 1'b0;
            end
        end
        if (rdv_reg)
        begin
            act_next = 1'b1;
            col_next = 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg    <= 1'b0;
            act_reg    <= 1'b0;
            col_reg    <= 3'd0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            rdv_reg    <= rd_en;
            act_reg    <= act_next;
            col_reg    <= col_next;
            strobe_reg <= act_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdv_reg)
        begin
            glyph_reg     <= tgcg_pkg::glyph_cols(rd_cell.code);
            cell_last_reg <= rd_cell.last;
        end
        byte_reg <= byte_next;
        last_reg <= act_reg && final_col && cell_last_reg;
    end

    assign strobe      = strobe_reg;
    assign column_byte = byte_reg;
    assign last        = last_reg;

endmodule

/* hdl/text_glyph_column_generator_unit.sv */
// Character generator for a column-addressed monochrome LCD.
// Input: an item is transferred on a rising edge with start high and busy low.
// mode low renders char_code as its 5x7 glyph plus a blank column; mode high
// renders number in decimal without leading zeros, six columns per digit.
// Output: each column appears on column_byte for one cycle with strobe high;
// last marks the final column of an item. The receiver cannot stall.
// Cells (one character or one digit) wait in a 16-entry queue memory; digits
// come out of a converter that settles one digit position per cycle.
// From an idle block, a character's cell is written into the queue at its
// transfer edge, then read from the queue memory, its glyph loaded and its
// first column registered onto the outputs; a number's first cell is only
// written once the converter passes the leading zeros.
// Throughput: one column per cycle while cells wait in the queue, set by the
// single output column; a character is six columns, a number six to thirty.
// busy is high while a number conversion runs and while fewer than five queue
// entries are free; a new item is taken while earlier cells are still shown.
// Reset empties the queue and stops any output; no clearing pass is needed.
`include "text_glyph_column_generator_unit_macros.svh"

module text_glyph_column_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        mode,
    input  logic [7:0]  char_code,
    input  logic [15:0] number,
    output logic        strobe,
    output logic [7:0]  column_byte,
    output logic        last
);

    logic                              accept;
    logic                              conv_active;
    tgcg_pkg::wr_t                     wr;
    logic                              rd_en;
    tgcg_pkg::cell_t                   rd_cell;
    logic [tgcg_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tgcg_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tgcg_pkg::COUNT_W-1:0]      cnt_reg, cnt_next;

    assign busy   = conv_active
                    || (cnt_reg > tgcg_pkg::COUNT_W'(tgcg_pkg::FREE_LIMIT));
    assign accept = start && !busy;

    tgcg_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .mode      (mode),
        .char_code (char_code),
        .number    (number),
        .active    (conv_active),
        .wr        (wr)
    );

    tgcg_ram #(
        .WIDTH (tgcg_pkg::CELL_W),
        .DEPTH (tgcg_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr_ptr_reg),
        .wdata (wr.entry),
        .raddr (rd_ptr_reg),
        .rdata (rd_cell)
    );

    tgcg_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .avail       (cnt_reg != '0),
        .rd_cell     (rd_cell),
        .rd_en       (rd_en),
        .strobe      (strobe),
        .column_byte (column_byte),
        .last        (last)
    );

    // Reads only take entries written in earlier cycles, so a read never
    // returns an entry that is being written in the same cycle.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + tgcg_pkg::QUEUE_AW'(wr.en);
        rd_ptr_next = rd_ptr_reg + tgcg_pkg::QUEUE_AW'(rd_en);
        cnt_next    = cnt_reg + tgcg_pkg::COUNT_W'(wr.en) - tgcg_pkg::COUNT_W'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `TGCG_ASSERT_ALWAYS(a_no_overflow, !(wr.en && cnt_reg == tgcg_pkg::COUNT_W'(tgcg_pkg::QUEUE_DEPTH)), "cell written into a full queue")
    `TGCG_ASSERT_ALWAYS(a_no_underflow, !(rd_en && cnt_reg == '0), "cell read from an empty queue")
    `TGCG_ASSERT_NEXT(a_number_starts, accept && mode == tgcg_pkg::MODE_NUMBER, conv_active, "number transfer did not start the converter")
    `TGCG_ASSERT_ALWAYS(a_last_has_strobe, !last || strobe, "last column without strobe")

endmodule

/* bench/tgcg_column_checker.sv */
module tgcg_column_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        mode,
    input  logic [7:0]  char_code,
    input  logic [15:0] number,
    input  logic        strobe,
    input  logic [7:0]  column_byte,
    input  logic        last,
    output int          errors,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] GLYPH_LO   = 8'h20;
    localparam logic [7:0] GLYPH_HI   = 8'h80;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] SPACER_COL = 8'h00;
    localparam int         GLYPH_COLS = 5;

    // Five columns per glyph, leftmost column in the most significant byte.
    localparam logic [39:0] FONT [0:96] = '{
        40'h0000000000, 40'h00005f0000, 40'h0007000700, 40'h147f147f14,
        40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
        40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
        40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
        40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
        40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
        40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
        40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
        40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
        40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
        40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
        40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
        40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
        40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
        40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
        40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
        40'h00007f0000, 40'h0041360800, 40'h1008081008, 40'h1f247c241f,
        40'h0006090906
    };

    typedef struct {
        logic [7:0] pixels;
        logic       tail;
    } column_t;

    column_t column_q[$];
    column_t want;

    // Queues the six columns of one character cell; codes outside the font are blank.
    function automatic void push_cell(input logic [7:0] code);
        logic [39:0] glyph;
        column_t     col;
        glyph = 40'h0;
        if (code >= GLYPH_LO && code <= GLYPH_HI)
        begin
            glyph = FONT[code - GLYPH_LO];
        end
        col.tail = 1'b0;
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            col.pixels = glyph[39 - 8 * c -: 8];
            column_q.push_back(col);
        end
        col.pixels = SPACER_COL;
        column_q.push_back(col);
    endfunction

    function automatic void render_item(input logic m, input logic [7:0] code,
                                        input logic [15:0] value);
        int unsigned v;
        int unsigned weight;
        bit          leading;
        v = value;
        if (m == tgcg_pkg::MODE_CHAR)
        begin
            push_cell(code);
        end
        else
        begin
            // Leading zeros are dropped, but the units digit always shows.
            weight = 10000;
            leading = 1'b1;
            while (weight > 0)
            begin
                if (!leading || (v / weight) != 0 || weight == 1)
                begin
                    leading = 1'b0;
                    push_cell(ZERO_CHAR + 8'((v / weight) % 10));
                end
                weight = weight / 10;
            end
        end
        column_q[column_q.size() - 1].tail = 1'b1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                render_item(mode, char_code, number);
            end
            if (strobe)
            begin
                if (column_q.size() == 0)
                begin
                    $error("column_byte: no column pending, got %h", column_byte);
                    errors++;
                end
                else
                begin
                    want = column_q.pop_front();
                    if (column_byte !== want.pixels)
                    begin
                        $error("column_byte: expected %h, got %h", want.pixels, column_byte);
                        errors++;
                    end
                    if (last !== want.tail)
                    begin
                        $error("last: expected %b, got %b", want.tail, last);
                        errors++;
                    end
                end
            end
        end
        outstanding = column_q.size();
    end

endmodule

/* bench/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_FROM    = 320;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        mode = tgcg_pkg::MODE_CHAR;
    logic [7:0]  char_code = 8'h00;
    logic [15:0] number = 16'h0000;
    logic        busy;
    logic        strobe;
    logic [7:0]  column_byte;
    logic        last;
    int          errors;
    int          outstanding;

    always #5 clk = ~clk;

    text_glyph_column_generator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .char_code   (char_code),
        .number      (number),
        .strobe      (strobe),
        .column_byte (column_byte),
        .last        (last)
    );

    tgcg_column_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .char_code   (char_code),
        .number      (number),
        .strobe      (strobe),
        .column_byte (column_byte),
        .last        (last),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // Holds the request until the block takes it; start is left high for a
    // back-to-back transfer and lowered only by the idle or drain tasks.
    task automatic send(input logic m, input logic [7:0] code, input logic [15:0] value);
        start     <= 1'b1;
        mode      <= m;
        char_code <= code;
        number    <= value;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic idle(input int cycles);
        start     <= 1'b0;
        mode      <= 1'($urandom);
        char_code <= 8'($urandom);
        number    <= 16'($urandom);
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (outstanding != 0);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_number();
        case ($urandom_range(1, 5))
            1:       return 16'($urandom_range(0, 9));
            2:       return 16'($urandom_range(10, 99));
            3:       return 16'($urandom_range(100, 999));
            4:       return 16'($urandom_range(1000, 9999));
            default: return 16'($urandom_range(10000, 65535));
        endcase
    endfunction

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0] code;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Font edges, codes just outside it, and both extremes of the byte.
        send(tgcg_pkg::MODE_CHAR, 8'h00, 16'hffff);
        send(tgcg_pkg::MODE_CHAR, 8'h1f, 16'h0000);
        send(tgcg_pkg::MODE_CHAR, 8'h20, 16'h1234);
        send(tgcg_pkg::MODE_CHAR, 8'h21, 16'h0000);
        send(tgcg_pkg::MODE_CHAR, 8'h41, 16'h0000);
        send(tgcg_pkg::MODE_CHAR, 8'h7f, 16'h0000);
        send(tgcg_pkg::MODE_CHAR, 8'h80, 16'h0000);
        send(tgcg_pkg::MODE_CHAR, 8'h81, 16'h0000);
        send(tgcg_pkg::MODE_CHAR, 8'hff, 16'hffff);
        // Every digit count, its boundaries, zero and the largest value.
        send(tgcg_pkg::MODE_NUMBER, 8'hff, 16'd0);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd9);
        send(tgcg_pkg::MODE_NUMBER, 8'h41, 16'd10);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd99);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd100);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd999);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd1000);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd9999);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd10000);
        send(tgcg_pkg::MODE_NUMBER, 8'hff, 16'd65535);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd10203);
        send(tgcg_pkg::MODE_NUMBER, 8'h00, 16'd12345);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 3)
            begin
                drain();
            end
            if ($urandom_range(0, 1) == 0)
            begin
                // Mostly printable glyphs, some codes anywhere in the byte.
                if ($urandom_range(0, 3) == 0)
                begin
                    code = 8'($urandom);
                end
                else
                begin
                    code = 8'($urandom_range(8'h20, 8'h80));
                end
                send(tgcg_pkg::MODE_CHAR, code, 16'($urandom));
            end
            else
            begin
                send(tgcg_pkg::MODE_NUMBER, 8'($urandom), pick_number());
            end
            // Every third stretch of forty items, and all items from CALM_FROM on, run without gaps.
            if (i < CALM_FROM && (i / 40) % 3 != 2 && $urandom_range(0, 2) == 0)
            begin
                idle($urandom_range(1, 7));
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
